FILE: src/tmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmt_pkg: shared types and constants of the terminus/endpoint mapping table
// Request and status codes, field widths and the control/status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package tmt_pkg;

  localparam int unsigned TableDepthDef = 256;
  localparam int unsigned IdW           = 8;
  localparam int unsigned CountW        = 9;
  localparam int unsigned PairW         = 2 * IdW;

  typedef enum logic [1:0] {
    REQ_MAP    = 2'd0,
    REQ_UNMAP  = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic    cap_req;     // latch request, restart scan
    logic    scan;        // issue next scan read, compare previous
    logic    cap_hit;     // latch index and endpoint of the matching entry
    logic    shift;       // move one entry down during unmap
    logic    load_res;    // load the result register
    logic    append;      // write request pair at the end of the table
    logic    remove;      // drop the last entry after a shift
    logic    res_hit_ep;  // result carries the captured endpoint
    status_e res_status;
  } tmt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       cnt_zero;
    logic       full;
    logic       cmp_vld;
    logic       cmp_hit;
    logic       cmp_last;
    logic       shift_done;
    logic       out_busy;
  } tmt_sts_t;

endpackage

FILE: src/tmt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmt_if: request and response channels of the mapping table
// Valid/ready channels; a request moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface tmt_req_if;
  import tmt_pkg::*;

  logic           valid;
  logic           ready;
  logic [1:0]     req_type;
  logic [IdW-1:0] terminus_id;
  logic [IdW-1:0] endpoint_id;

  modport source (output valid, output req_type, output terminus_id,
                  output endpoint_id, input ready);
  modport sink   (input valid, input req_type, input terminus_id,
                  input endpoint_id, output ready);
endinterface

interface tmt_rsp_if;
  import tmt_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [IdW-1:0]    found_endpoint;
  logic [CountW-1:0] entry_count;

  modport source (output valid, output status, output found_endpoint,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found_endpoint,
                  input entry_count, output ready);
endinterface

FILE: src/tid_to_eid_mapping_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tid_to_eid_mapping_table: ordered terminus-to-endpoint pair table
// Map appends a new pair, unmap removes a pair and closes the gap, lookup
// returns the endpoint of the first entry with a matching terminus.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Payload                                     | Per request
//  --------+-----+---------------------------------------------+------------
//  req_i   | in  | req_type, terminus_id, endpoint_id          | one
//  rsp_o   | out | status, found_endpoint, entry_count         | one
//
// Scan: a map, lookup or missing unmap reads the entries in order and stops
// early when a map or lookup hits; an unmap that hits stops the scan at the
// hit, and the shift then moves only the entries behind it, one per cycle on
// the single read port.
// Reset: clears count and control; the pair RAM is not cleared, only entries below the count are read.
// Stalls: a finished result waits in the output register; the next request
// is taken meanwhile, but its result is held back until the previous leaves.
// ----------------------------------------------------------------------------
module tid_to_eid_mapping_table #(
  parameter int unsigned TableDepth = tmt_pkg::TableDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tmt_req_if.sink   req_i,
  tmt_rsp_if.source rsp_o
);
  import tmt_pkg::*;

  tmt_cmd_t cmd;
  tmt_sts_t sts;

  // Sequencer: one request at a time, scan -> (shift) -> result
  tmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Table storage, pointers, compare and result register
  tmt_dp #(
    .TableDepth (TableDepth)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_type_i       (req_i.req_type),
    .terminus_id_i    (req_i.terminus_id),
    .endpoint_id_i    (req_i.endpoint_id),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_ready_i      (rsp_o.ready),
    .status_o         (rsp_o.status),
    .found_endpoint_o (rsp_o.found_endpoint),
    .entry_count_o    (rsp_o.entry_count)
  );

endmodule

FILE: src/tmt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmt_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered. No reset.
// ----------------------------------------------------------------------------
module tmt_ram #(
  parameter int unsigned Width = tmt_pkg::PairW,
  parameter int unsigned Depth = tmt_pkg::TableDepthDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tmt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmt_ctrl: request sequencer of the mapping table
// Walks a request through scan, optional shift and result load.
// ----------------------------------------------------------------------------
module tmt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output tmt_pkg::tmt_cmd_t  cmd_o,
  input  tmt_pkg::tmt_sts_t  sts_i
);
  import tmt_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StShift = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StFin   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       hit_q, hit_d;
  logic       kind_ok;

  assign kind_ok = (sts_i.req_type == REQ_MAP) || (sts_i.req_type == REQ_UNMAP) ||
                   (sts_i.req_type == REQ_LOOKUP);

  always_comb begin
    state_d          = state_q;
    hit_d            = hit_q;
    cmd_o            = '0;
    cmd_o.res_status = ST_OK;
    req_ready_o      = 1'b0;
    unique case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.cap_req = 1'b1;
          hit_d         = 1'b0;
          state_d       = StScan;
        end
      end
      StScan: begin
        if (!kind_ok || sts_i.cnt_zero) begin
          state_d = StFin;
        end else begin
          cmd_o.scan = 1'b1;
          if (sts_i.cmp_vld && sts_i.cmp_hit) begin
            cmd_o.cap_hit = 1'b1;
            hit_d         = 1'b1;
            state_d       = (sts_i.req_type == REQ_UNMAP) ? StShift : StFin;
          end else if (sts_i.cmp_vld && sts_i.cmp_last) begin
            state_d = StFin;
          end
        end
      end
      StShift: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StFin;
      end
      StFin: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_res = 1'b1;
          state_d        = StIdle;
          unique case (sts_i.req_type)
            REQ_MAP: begin
              if (!hit_q) begin
                if (sts_i.full) begin
                  cmd_o.res_status = ST_FULL;
                end else begin
                  cmd_o.append = 1'b1;
                end
              end
            end
            REQ_UNMAP: begin
              cmd_o.remove = hit_q;
            end
            REQ_LOOKUP: begin
              if (hit_q) begin
                cmd_o.res_hit_ep = 1'b1;
              end else begin
                cmd_o.res_status = ST_NOT_FOUND;
              end
            end
            default: begin
              cmd_o.res_status = ST_OK;
            end
          endcase
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      hit_q   <= hit_d;
    end
  end

endmodule

FILE: src/tmt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmt_dp: datapath of the mapping table
// Pair RAM, entry count, scan and shift pointers, compare and result register.
// ----------------------------------------------------------------------------
module tmt_dp #(
  parameter int unsigned TableDepth = tmt_pkg::TableDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    req_type_i,
  input  logic [tmt_pkg::IdW-1:0]       terminus_id_i,
  input  logic [tmt_pkg::IdW-1:0]       endpoint_id_i,
  input  tmt_pkg::tmt_cmd_t             cmd_i,
  output tmt_pkg::tmt_sts_t             sts_o,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [1:0]                    status_o,
  output logic [tmt_pkg::IdW-1:0]       found_endpoint_o,
  output logic [tmt_pkg::CountW-1:0]    entry_count_o
);
  import tmt_pkg::*;

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CntW  = $clog2(TableDepth + 1);

  // Request latch
  logic [1:0]     req_type_q;
  logic [IdW-1:0] tid_q, eid_q;

  // Table bookkeeping
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scan_idx_q;
  logic [CntW-1:0] cmp_idx_q;
  logic            cmp_vld_q;
  logic [CntW-1:0] sh_q, sh_next;
  logic            wr_pend_q;
  logic [CntW-1:0] wr_addr_q;
  logic [IdW-1:0]  hit_ep_q;
  logic            scan_go, sh_go;

  // Result register
  logic              rsp_valid_q;
  status_e           res_status_q;
  logic [IdW-1:0]    res_ep_q;
  logic [CountW-1:0] res_cnt_q;
  logic [CntW+CountW-1:0] cnt_ext;

  // RAM ports
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [PairW-1:0] ram_wdata, ram_rdata;

  assign scan_go = cmd_i.scan && (scan_idx_q < count_q);
  assign sh_next = sh_q + CntW'(1);
  assign sh_go   = cmd_i.shift && (sh_next < count_q);

  assign ram_raddr = cmd_i.shift ? sh_next[AddrW-1:0] : scan_idx_q[AddrW-1:0];
  assign ram_we    = wr_pend_q || cmd_i.append;
  assign ram_waddr = wr_pend_q ? wr_addr_q[AddrW-1:0] : count_q[AddrW-1:0];
  assign ram_wdata = wr_pend_q ? ram_rdata : {tid_q, eid_q};

  tmt_ram #(
    .Width (PairW),
    .Depth (TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.append) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.remove) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign cnt_ext = {{CountW{1'b0}}, count_d};

  always_comb begin
    sts_o            = '0;
    sts_o.req_type   = req_type_q;
    sts_o.cnt_zero   = (count_q == '0);
    sts_o.full       = (count_q == CntW'(TableDepth));
    sts_o.cmp_vld    = cmp_vld_q;
    sts_o.cmp_hit    = (req_type_q == REQ_LOOKUP) ? (ram_rdata[PairW-1:IdW] == tid_q)
                                                   : (ram_rdata == {tid_q, eid_q});
    sts_o.cmp_last   = (cmp_idx_q == (count_q - CntW'(1)));
    sts_o.shift_done = !(sh_next < count_q);
    sts_o.out_busy   = rsp_valid_q && !rsp_ready_i;
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_req) begin
      req_type_q <= req_type_i;
      tid_q      <= terminus_id_i;
      eid_q      <= endpoint_id_i;
    end
    if (scan_go) begin
      cmp_idx_q <= scan_idx_q;
    end
    if (cmd_i.cap_hit) begin
      sh_q     <= cmp_idx_q;
      hit_ep_q <= ram_rdata[IdW-1:0];
    end else if (sh_go) begin
      sh_q <= sh_next;
    end
    wr_addr_q <= sh_q;
    if (cmd_i.load_res) begin
      res_status_q <= cmd_i.res_status;
      res_ep_q     <= cmd_i.res_hit_ep ? hit_ep_q : '0;
      res_cnt_q    <= cnt_ext[CountW-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_idx_q  <= '0;
      cmp_vld_q   <= 1'b0;
      wr_pend_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      wr_pend_q <= sh_go;
      if (cmd_i.cap_req) begin
        scan_idx_q <= '0;
        cmp_vld_q  <= 1'b0;
      end else begin
        cmp_vld_q <= scan_go;
        if (scan_go) begin
          scan_idx_q <= scan_idx_q + CntW'(1);
        end
      end
      if (cmd_i.load_res) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o      = rsp_valid_q;
  assign status_o         = res_status_q;
  assign found_endpoint_o = res_ep_q;
  assign entry_count_o    = res_cnt_q;

endmodule

FILE: src/tmt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmt_checker: port-level checks of the mapping table
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module tmt_checker #(
  parameter int unsigned TableDepth = tmt_pkg::TableDepthDef
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [1:0]                 status_i,
  input logic [tmt_pkg::IdW-1:0]    found_endpoint_i,
  input logic [tmt_pkg::CountW-1:0] entry_count_i
);
  import tmt_pkg::*;

  localparam logic [CountW-1:0] FullCnt = CountW'(TableDepth);

  // Held response stays put
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) &&
      $stable(found_endpoint_i) && $stable(entry_count_i))
    else $error("response changed while stalled");

  // Table full only reported with every entry in use
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_FULL) |-> entry_count_i == FullCnt)
    else $error("table full reported below capacity");

  // An endpoint is only returned with an ok status
  a_ep_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (found_endpoint_i != '0) |-> status_i == ST_OK)
    else $error("endpoint returned with error status");

  // One request in flight: no back-to-back accept
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while busy");

endmodule

bind tid_to_eid_mapping_table tmt_checker #(
  .TableDepth (TableDepth)
) u_tmt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .status_i         (rsp_o.status),
  .found_endpoint_i (rsp_o.found_endpoint),
  .entry_count_i    (rsp_o.entry_count)
);
